[hw/rtl/line_length_limit_scanner_assert.svh]
// Assertion macros for the line length scanner.
`ifndef LINE_LENGTH_LIMIT_SCANNER_ASSERT_SVH
`define LINE_LENGTH_LIMIT_SCANNER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define LLLS_ASSERT_IMPLY(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("llls: implication check failed");

// Next-cycle implication, checked out of reset.
`define LLLS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("llls: next-cycle check failed");

`endif

[hw/rtl/llls_pkg.sv]
package llls_pkg;

  localparam int unsigned LINE_LEN_W   = 16;
  localparam int unsigned COUNT_W      = 32;
  localparam int unsigned LIMIT_W      = 16;

  localparam int unsigned LENGTH_BITS_DEFAULT = 16;
  localparam int unsigned COUNT_BITS_DEFAULT  = 32;

  localparam logic [7:0]         CHAR_LF     = 8'h0A;
  localparam logic [7:0]         CHAR_CR     = 8'h0D;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(156);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_end;
  } item_t;

  typedef struct packed {
    logic                  line_valid;
    logic [COUNT_W-1:0]    line_number;
    logic [LINE_LEN_W-1:0] line_length;
    logic                  over_limit;
    logic [LINE_LEN_W-1:0] longest_length;
    logic [COUNT_W-1:0]    longest_line_number;
    logic [COUNT_W-1:0]    over_count;
    logic                  end_of_file;
  } result_t;

endpackage

[hw/rtl/line_length_limit_scanner.sv]
// Line length scanner: splits a byte stream into lines (CR or LF ends a line,
// one directly following CR or LF is its partner) and reports each line.
// Input channel item_valid/item_stall/item carries one byte and a last-byte
// flag per transfer. Result channel result_valid/result_stall/result carries
// the line number, length, limit flag and running totals; the last byte of a
// file always gives one result with end_of_file set, after which the totals
// clear. Partner bytes, and ordinary bytes that are not the last, give none.
// limit_write_enable/limit_write_data set the length limit; write it only
// while the block is idle.
// A byte's transfer loads the input register; the result register is then loaded
// from the input register when the output is not stalled.
// Throughput: one byte per cycle while result_stall does not hold a pending result.
// Reset (rst, synchronous) empties both registers, clears the line state and
// sets the limit to 156. While result_stall holds a pending result, the byte
// in the input register waits and item_stall is raised; nothing is lost.
module line_length_limit_scanner #(
  parameter int unsigned LENGTH_BITS = llls_pkg::LENGTH_BITS_DEFAULT,
  parameter int unsigned COUNT_BITS  = llls_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_stall,
  input  llls_pkg::item_t              item,
  output logic                         result_valid,
  input  logic                         result_stall,
  output llls_pkg::result_t            result,
  input  logic                         limit_write_enable,
  input  logic [llls_pkg::LIMIT_W-1:0] limit_write_data
);

  `include "line_length_limit_scanner_assert.svh"

  logic                         stage_valid;
  llls_pkg::item_t              stage_item;
  logic [llls_pkg::LIMIT_W-1:0] limit;
  logic                         advance;
  logic                         step;
  logic                         core_has_result;
  llls_pkg::result_t            core_result;

  assign advance    = !result_valid || !result_stall;
  assign step       = stage_valid && advance;
  assign item_stall = stage_valid && !advance;

  llls_core #(
    .LENGTH_BITS (LENGTH_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .item       (stage_item),
    .limit      (limit),
    .has_result (core_has_result),
    .result     (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= llls_pkg::LIMIT_RESET;
    end else if (limit_write_enable) begin
      limit <= limit_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      stage_item <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= step && core_has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= core_result;
    end
  end

  `LLLS_ASSERT_IMPLY(a_no_line_is_eof, result_valid && !result.line_valid, result.end_of_file)
  `LLLS_ASSERT_IMPLY(a_no_line_zero, result_valid && !result.line_valid, (result.line_number == '0) && (result.line_length == '0) && !result.over_limit)
  `LLLS_ASSERT_IMPLY(a_over_needs_line, result_valid && result.over_limit, result.line_valid)
  `LLLS_ASSERT_NEXT(a_stall_holds_stage, stage_valid && item_stall, stage_valid)

endmodule

[hw/rtl/llls_core.sv]
module llls_core #(
  parameter int unsigned LENGTH_BITS = llls_pkg::LENGTH_BITS_DEFAULT,
  parameter int unsigned COUNT_BITS  = llls_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  llls_pkg::item_t               item,
  input  logic [llls_pkg::LIMIT_W-1:0]  limit,
  output logic                          has_result,
  output llls_pkg::result_t             result
);

  localparam int unsigned CMP_W =
    (LENGTH_BITS > llls_pkg::LIMIT_W) ? LENGTH_BITS : llls_pkg::LIMIT_W;

  logic                   after_term;
  logic [LENGTH_BITS-1:0] cur_len;
  logic [COUNT_BITS-1:0]  lines;
  logic [LENGTH_BITS-1:0] max_len;
  logic [COUNT_BITS-1:0]  max_line;
  logic [COUNT_BITS-1:0]  over_cnt;

  logic                   after_term_next;
  logic [LENGTH_BITS-1:0] cur_len_next;
  logic [COUNT_BITS-1:0]  lines_next;
  logic [LENGTH_BITS-1:0] max_len_next;
  logic [COUNT_BITS-1:0]  max_line_next;
  logic [COUNT_BITS-1:0]  over_cnt_next;

  logic                   term;
  logic                   eof;
  logic                   finish;
  logic                   over;
  logic                   new_max;
  logic [LENGTH_BITS-1:0] cur_inc;
  logic [LENGTH_BITS-1:0] line_len;
  logic [COUNT_BITS-1:0]  lines_inc;
  logic [COUNT_BITS-1:0]  over_inc;

  always_comb begin
    term      = (item.data_byte == llls_pkg::CHAR_LF) || (item.data_byte == llls_pkg::CHAR_CR);
    eof       = item.file_end;
    cur_inc   = (cur_len == '1) ? cur_len : cur_len + LENGTH_BITS'(1);
    lines_inc = (lines == '1) ? lines : lines + COUNT_BITS'(1);
    over_inc  = (over_cnt == '1) ? over_cnt : over_cnt + COUNT_BITS'(1);
    line_len  = term ? cur_len : cur_inc;
    finish    = (term && !after_term && !(eof && (cur_len == '0))) || (!term && eof);
    has_result = eof || (term && !after_term);
    over      = CMP_W'(line_len) > CMP_W'(limit);
    new_max   = finish && (line_len > max_len);

    max_len_next  = new_max ? line_len : max_len;
    max_line_next = new_max ? lines_inc : max_line;
    over_cnt_next = (finish && over) ? over_inc : over_cnt;
    lines_next    = finish ? lines_inc : lines;
    cur_len_next  = term ? '0 : cur_inc;
    after_term_next = term && !after_term;
  end

  always_comb begin
    result.line_valid          = finish;
    result.line_number         = finish ? llls_pkg::COUNT_W'(lines_inc) : '0;
    result.line_length         = finish ? llls_pkg::LINE_LEN_W'(line_len) : '0;
    result.over_limit          = finish && over;
    result.longest_length      = llls_pkg::LINE_LEN_W'(max_len_next);
    result.longest_line_number = llls_pkg::COUNT_W'(max_line_next);
    result.over_count          = llls_pkg::COUNT_W'(over_cnt_next);
    result.end_of_file         = eof;
  end

  // end of file clears the per-file state
  always_ff @(posedge clk) begin
    if (rst) begin
      after_term <= 1'b0;
      cur_len    <= '0;
      lines      <= '0;
      max_len    <= '0;
      max_line   <= '0;
      over_cnt   <= '0;
    end else if (step) begin
      if (eof) begin
        after_term <= 1'b0;
        cur_len    <= '0;
        lines      <= '0;
        max_len    <= '0;
        max_line   <= '0;
        over_cnt   <= '0;
      end else begin
        after_term <= after_term_next;
        cur_len    <= cur_len_next;
        lines      <= lines_next;
        max_len    <= max_len_next;
        max_line   <= max_line_next;
        over_cnt   <= over_cnt_next;
      end
    end
  end

endmodule
